>>> src/line_follow_guidance_macros.svh
// ----------------------------------------------------------------------------
// line_follow_guidance_macros.svh
// Assertion shorthands for the line-following guidance block.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_GUIDANCE_MACROS_SVH
`define LINE_FOLLOW_GUIDANCE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define LFG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line_follow_guidance: check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define LFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line_follow_guidance: check failed");

`endif

>>> src/lfg_pkg.sv
// ----------------------------------------------------------------------------
// lfg_pkg
// Shared types, constants and tables for the line-following guidance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfg_pkg;

  localparam int POS_FRAC_BITS   = 16;
  localparam int CORDIC_ITER_DEF = 16;
  localparam int ITER_W          = 5;
  localparam int SQRT_STEPS      = 25;
  localparam int SQRT_TOP        = 2 * (SQRT_STEPS - 1);
  localparam int DW              = 36;
  localparam int PW              = 70;
  localparam int RW              = 72;
  localparam int DIST_SHIFT      = POS_FRAC_BITS - 5;
  localparam int RATE_SHIFT      = POS_FRAC_BITS - 17;

  localparam logic signed [31:0] DEG180     = 32'sd754974720;
  localparam logic signed [33:0] INV_K_Q24  = 34'sd10188014;
  localparam logic signed [25:0] ONE_Q24    = 26'sd16777216;
  localparam logic signed [19:0] HEAD_LIMIT = 20'sd69120;

  typedef enum logic [2:0] {
    REG_START_X       = 3'd0,
    REG_START_Y       = 3'd1,
    REG_END_X         = 3'd2,
    REG_END_Y         = 3'd3,
    REG_ARRIVE_RADIUS = 3'd4,
    REG_DIST_GAIN     = 3'd5,
    REG_RATE_GAIN     = 3'd6,
    REG_SAMPLE_PERIOD = 3'd7
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRE,
    OP_DEGEN,
    OP_CORD,
    OP_MUL_EX,
    OP_MUL_EY,
    OP_MUL_LX,
    OP_UNS_END,
    OP_KDTS,
    OP_MUL_A,
    OP_MUL_B,
    OP_ACC,
    OP_CLAMP,
    OP_SQ,
    OP_ROOT_INIT,
    OP_ROOT,
    OP_ASIN_INIT,
    OP_HEAD
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PRE,
    S_CORD_L,
    S_MEX,
    S_MEY,
    S_MLX,
    S_UEND,
    S_KDTS,
    S_MA,
    S_MB,
    S_ACC,
    S_CLAMP,
    S_SQ,
    S_RINIT,
    S_ROOT,
    S_AINIT,
    S_CORD_A,
    S_HEAD
  } ctrl_state_e;

  typedef struct packed {
    op_e               op;
    logic [ITER_W-1:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic degenerate;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [30:0]        arrive_radius;
    logic [15:0]        dist_gain;
    logic [15:0]        rate_gain;
    logic [15:0]        sample_period;
  } cfg_t;

  function automatic logic signed [31:0] atan_step(input logic [ITER_W-1:0] i);
    longint t;
    begin
      case (i)
        5'd0:    t = 64'd188743680;
        5'd1:    t = 64'd111421900;
        5'd2:    t = 64'd58872272;
        5'd3:    t = 64'd29884485;
        5'd4:    t = 64'd15000234;
        5'd5:    t = 64'd7507429;
        5'd6:    t = 64'd3754631;
        5'd7:    t = 64'd1877430;
        5'd8:    t = 64'd938729;
        5'd9:    t = 64'd469366;
        5'd10:   t = 64'd234683;
        default: t = (64'd240315917 + (64'd1 << (i - 5'd1))) >> i;
      endcase
      return t[31:0];
    end
  endfunction

endpackage

>>> src/lfg_regs.sv
// ----------------------------------------------------------------------------
// lfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  output lfg_pkg::cfg_t cfg_o
);
  import lfg_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_START_X:       cfg_d.start_x       = cfg_data_i;
        REG_START_Y:       cfg_d.start_y       = cfg_data_i;
        REG_END_X:         cfg_d.end_x         = cfg_data_i;
        REG_END_Y:         cfg_d.end_y         = cfg_data_i;
        REG_ARRIVE_RADIUS: cfg_d.arrive_radius = cfg_data_i[30:0];
        REG_DIST_GAIN:     cfg_d.dist_gain     = cfg_data_i[15:0];
        REG_RATE_GAIN:     cfg_d.rate_gain     = cfg_data_i[15:0];
        REG_SAMPLE_PERIOD: cfg_d.sample_period = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x       <= '0;
      cfg_q.start_y       <= '0;
      cfg_q.end_x         <= '0;
      cfg_q.end_y         <= '0;
      cfg_q.arrive_radius <= 31'd131072;
      cfg_q.dist_gain     <= '0;
      cfg_q.rate_gain     <= '0;
      cfg_q.sample_period <= 16'd410;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/lfg_ctrl.sv
// ----------------------------------------------------------------------------
// lfg_ctrl
// Sequencer: steps the datapath through rotation, control law, root and asin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfg_ctrl #(
  parameter int CORDIC_ITERATIONS = lfg_pkg::CORDIC_ITER_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lfg_pkg::dp_status_t status_i,
  output lfg_pkg::dp_cmd_t    cmd_o
);
  import lfg_pkg::*;

  localparam logic [ITER_W-1:0] CORD_LAST = ITER_W'(CORDIC_ITERATIONS - 1);
  localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(SQRT_STEPS - 1);

  ctrl_state_e       state_q, state_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PRE;
      end
      S_PRE: begin
        cnt_d   = '0;
        state_d = status_i.degenerate ? S_KDTS : S_CORD_L;
      end
      S_CORD_L: begin
        if (cnt_q == CORD_LAST) begin
          cnt_d   = '0;
          state_d = S_MEX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MEX:   state_d = S_MEY;
      S_MEY:   state_d = S_MLX;
      S_MLX:   state_d = S_UEND;
      S_UEND:  state_d = S_KDTS;
      S_KDTS:  state_d = S_MA;
      S_MA:    state_d = S_MB;
      S_MB:    state_d = S_ACC;
      S_ACC:   state_d = S_CLAMP;
      S_CLAMP: state_d = S_SQ;
      S_SQ:    state_d = S_RINIT;
      S_RINIT: begin
        cnt_d   = '0;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (cnt_q == ROOT_LAST) begin
          cnt_d   = '0;
          state_d = S_AINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_AINIT: begin
        cnt_d   = '0;
        state_d = S_CORD_A;
      end
      S_CORD_A: begin
        if (cnt_q == CORD_LAST) begin
          cnt_d   = '0;
          state_d = S_HEAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_HEAD: begin
        if (!status_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.iter = cnt_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_PRE:    cmd_o.op = status_i.degenerate ? OP_DEGEN : OP_PRE;
      S_CORD_L: cmd_o.op = OP_CORD;
      S_MEX:    cmd_o.op = OP_MUL_EX;
      S_MEY:    cmd_o.op = OP_MUL_EY;
      S_MLX:    cmd_o.op = OP_MUL_LX;
      S_UEND:   cmd_o.op = OP_UNS_END;
      S_KDTS:   cmd_o.op = OP_KDTS;
      S_MA:     cmd_o.op = OP_MUL_A;
      S_MB:     cmd_o.op = OP_MUL_B;
      S_ACC:    cmd_o.op = OP_ACC;
      S_CLAMP:  cmd_o.op = OP_CLAMP;
      S_SQ:     cmd_o.op = OP_SQ;
      S_RINIT:  cmd_o.op = OP_ROOT_INIT;
      S_ROOT:   cmd_o.op = OP_ROOT;
      S_AINIT:  cmd_o.op = OP_ASIN_INIT;
      S_CORD_A: cmd_o.op = OP_CORD;
      S_HEAD: begin
        if (!status_i.out_busy) cmd_o.op = OP_HEAD;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> src/lfg_dp.sv
// ----------------------------------------------------------------------------
// lfg_dp
// Datapath: shared CORDIC, one registered multiplier, integer square root,
// control law state and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfg_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfg_pkg::dp_cmd_t    cmd_i,
  output lfg_pkg::dp_status_t status_o,
  input  lfg_pkg::cfg_t       cfg_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [17:0]  heading_o,
  output logic signed [31:0]  cross_track_o,
  output logic                arrived_o
);
  import lfg_pkg::*;

  localparam int RS_R = (RATE_SHIFT >= 0) ? RATE_SHIFT : 0;
  localparam int RS_L = (RATE_SHIFT < 0) ? -RATE_SHIFT : 0;

  logic signed [DW-1:0] x_q, y_q, px_q, py_q;
  logic signed [31:0]   z_q, beta_q;
  logic signed [PW-1:0] p_q;
  logic signed [DW-1:0] xn_q, yn_q, xend_q;
  logic signed [31:0]   d_q, integ_q, wc_q, prev_q;
  logic signed [RW-1:0] a_q;
  logic signed [25:0]   psi_q;
  logic [49:0]          n_q, res_q;
  logic                 out_valid_q;
  logic signed [17:0]   heading_q;
  logic signed [31:0]   cross_q;
  logic                 arrived_q;

  logic signed [DW-1:0] xs, ys, pxs, pys;
  logic signed [31:0]   ang;
  logic signed [DW-1:0] ma;
  logic signed [33:0]   mb;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] unsc_full;
  logic signed [DW-1:0] unsc;
  logic signed [DW:0]   neg_yn;
  logic signed [31:0]   d_sat;
  logic signed [RW-1:0] p_ext, resc_a, resc_b;
  logic signed [RW+1:0] acc;
  logic signed [31:0]   acc_sat;
  logic signed [25:0]   psi_c;
  logic [5:0]           sq_sh;
  logic [49:0]          sq_bit, sq_try;
  logic signed [33:0]   hsum;
  logic signed [19:0]   hround, hclamp;
  logic signed [39:0]   arr_lim;
  logic signed [32:0]   diff;

  // cordic micro-rotation operands
  assign xs  = x_q >>> cmd_i.iter;
  assign ys  = y_q >>> cmd_i.iter;
  assign pxs = px_q >>> cmd_i.iter;
  assign pys = py_q >>> cmd_i.iter;
  assign ang = atan_step(cmd_i.iter);

  assign diff = 33'(d_q) - 33'(prev_q);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_MUL_EX: begin ma = px_q; mb = INV_K_Q24; end
      OP_MUL_EY: begin ma = py_q; mb = INV_K_Q24; end
      OP_MUL_LX: begin ma = x_q;  mb = INV_K_Q24; end
      OP_KDTS: begin
        ma = DW'(signed'({1'b0, cfg_i.dist_gain}));
        mb = 34'(signed'({1'b0, cfg_i.sample_period}));
      end
      OP_MUL_A: begin
        ma = DW'(d_q);
        mb = 34'(signed'({1'b0, p_q[31:0]}));
      end
      OP_MUL_B: begin
        ma = DW'(diff);
        mb = 34'(signed'({1'b0, cfg_i.rate_gain}));
      end
      OP_SQ: begin
        ma = DW'(psi_q);
        mb = 34'(psi_q);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod      = PW'(ma) * PW'(mb);
  assign unsc_full = (p_q + PW'(64'sd8388608)) >>> 24;
  assign unsc      = unsc_full[DW-1:0];

  assign neg_yn = -(DW+1)'(yn_q);
  always_comb begin
    if (neg_yn > (DW+1)'(32'sh7fffffff))         d_sat = 32'sh7fffffff;
    else if (neg_yn < -(DW+1)'(33'sh080000000))  d_sat = 32'sh80000000;
    else                                         d_sat = neg_yn[31:0];
  end

  assign p_ext  = RW'(p_q);
  assign resc_a = p_ext >>> DIST_SHIFT;
  assign resc_b = (RATE_SHIFT >= 0) ? (p_ext >>> RS_R) : (p_ext <<< RS_L);
  assign acc    = (RW+2)'(integ_q) + (RW+2)'(wc_q) - (RW+2)'(a_q) - (RW+2)'(resc_b);

  always_comb begin
    if (acc > (RW+2)'(32'sh7fffffff))          acc_sat = 32'sh7fffffff;
    else if (acc < -(RW+2)'(33'sh080000000))   acc_sat = 32'sh80000000;
    else                                       acc_sat = acc[31:0];
  end

  always_comb begin
    if (integ_q > 32'(ONE_Q24))       psi_c = ONE_Q24;
    else if (integ_q < -32'(ONE_Q24)) psi_c = -ONE_Q24;
    else                              psi_c = integ_q[25:0];
  end

  // square root: one result bit per step
  assign sq_sh  = 6'(SQRT_TOP) - {cmd_i.iter, 1'b0};
  assign sq_bit = 50'd1 << sq_sh;
  assign sq_try = res_q + sq_bit;

  assign hsum   = 34'(beta_q) - 34'(z_q) + 34'sd8192;
  assign hround = 20'(hsum >>> 14);
  always_comb begin
    if (hround > HEAD_LIMIT)       hclamp = HEAD_LIMIT;
    else if (hround < -HEAD_LIMIT) hclamp = -HEAD_LIMIT;
    else                           hclamp = hround;
  end

  assign arr_lim = 40'(xend_q) - 40'(signed'({1'b0, cfg_i.arrive_radius}));

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x_q  <= DW'(33'(cfg_i.end_x) - 33'(cfg_i.start_x));
        y_q  <= DW'(33'(cfg_i.end_y) - 33'(cfg_i.start_y));
        px_q <= DW'(33'(pos_x_i) - 33'(cfg_i.start_x));
        py_q <= DW'(33'(pos_y_i) - 33'(cfg_i.start_y));
      end
      OP_PRE: begin
        if (x_q[DW-1]) begin
          z_q  <= y_q[DW-1] ? -DEG180 : DEG180;
          x_q  <= -x_q;
          y_q  <= -y_q;
          px_q <= -px_q;
          py_q <= -py_q;
        end else begin
          z_q <= '0;
        end
      end
      OP_DEGEN: begin
        xn_q   <= px_q;
        yn_q   <= py_q;
        xend_q <= '0;
        beta_q <= '0;
      end
      OP_CORD: begin
        if (!y_q[DW-1]) begin
          x_q  <= x_q + ys;
          y_q  <= y_q - xs;
          px_q <= px_q + pys;
          py_q <= py_q - pxs;
          z_q  <= z_q + ang;
        end else begin
          x_q  <= x_q - ys;
          y_q  <= y_q + xs;
          px_q <= px_q - pys;
          py_q <= py_q + pxs;
          z_q  <= z_q - ang;
        end
      end
      OP_MUL_EX: begin
        beta_q <= z_q;
        p_q    <= prod;
      end
      OP_MUL_EY: begin
        xn_q <= unsc;
        p_q  <= prod;
      end
      OP_MUL_LX: begin
        yn_q <= unsc;
        p_q  <= prod;
      end
      OP_UNS_END: xend_q <= unsc;
      OP_KDTS: begin
        d_q <= d_sat;
        p_q <= prod;
      end
      OP_MUL_A: p_q <= prod;
      OP_MUL_B: begin
        a_q <= resc_a;
        p_q <= prod;
      end
      OP_CLAMP: psi_q <= psi_c;
      OP_SQ:    p_q   <= prod;
      OP_ROOT_INIT: begin
        n_q   <= (50'd1 << SQRT_TOP) - p_q[49:0];
        res_q <= '0;
      end
      OP_ROOT: begin
        if (n_q >= sq_try) begin
          n_q   <= n_q - sq_try;
          res_q <= (res_q >> 1) + sq_bit;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      OP_ASIN_INIT: begin
        x_q  <= DW'(signed'({1'b0, res_q[25:0]}));
        y_q  <= DW'(psi_q);
        px_q <= '0;
        py_q <= '0;
        z_q  <= '0;
      end
      OP_HEAD: begin
        heading_q <= hclamp[17:0];
        cross_q   <= d_q;
        arrived_q <= 40'(xn_q) > arr_lim;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      wc_q        <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_ACC) integ_q <= acc_sat;
      if (cmd_i.op == OP_CLAMP) begin
        wc_q   <= 32'(psi_c) - integ_q;
        prev_q <= d_q;
      end
      if (cmd_i.op == OP_HEAD)  out_valid_q <= 1'b1;
      else if (out_ready_i)     out_valid_q <= 1'b0;
    end
  end

  assign status_o.degenerate = (x_q == '0) && (y_q == '0);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign heading_o     = heading_q;
  assign cross_track_o = cross_q;
  assign arrived_o     = arrived_q;

endmodule

>>> src/line_follow_guidance.sv
// ----------------------------------------------------------------------------
// line_follow_guidance
// Turns each vehicle position into a heading command for following a line.
// ----------------------------------------------------------------------------
// Usage:
//   Program the line end points, arrival radius, gains and sample period on
//   the write port while the block is idle. Offer one position per beat on
//   the input channel (pos_x_i, pos_y_i); each beat yields one result beat of
//   heading_o, cross_track_o and arrived_o.
//   The result is offered after the two CORDIC passes and the 25-step
//   square root, all on shared units; the first CORDIC pass is skipped
//   when the line start equals its end. One item is worked at a time. A
//   new input beat is taken as soon as the previous result sits in the
//   output register.
//   Reset clears the steering state and loads the register defaults.
//   While the receiver stalls, the result holds in the output register and
//   the block waits before writing the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follow_guidance #(
  parameter int CORDIC_ITERATIONS = lfg_pkg::CORDIC_ITER_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [17:0]  heading_o,
  output logic signed [31:0]  cross_track_o,
  output logic                arrived_o
);
  import lfg_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  lfg_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lfg_ctrl #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfg_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_i         (cfg),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .heading_o     (heading_o),
    .cross_track_o (cross_track_o),
    .arrived_o     (arrived_o)
  );

endmodule

>>> src/lfg_checker.sv
// ----------------------------------------------------------------------------
// lfg_checker
// Port-level checks on the guidance block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_follow_guidance_macros.svh"

module lfg_sva (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [17:0] heading_o
);

  localparam logic signed [17:0] HMAX = 18'sd69120;

  `LFG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `LFG_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o)
  `LFG_ASSERT_SAME(a_head_range, out_valid_o, (heading_o <= HMAX) && (heading_o >= -HMAX))

endmodule

bind line_follow_guidance lfg_sva u_lfg_sva (.*);
